// ===== rtl/wfha_pkg.sv =====
package wfha_pkg;

  localparam int unsigned ADDR_BITS     = 16;
  localparam int unsigned AW            = 17;
  localparam logic [AW-1:0] ADDR_LIMIT  = AW'(1) << ADDR_BITS;
  localparam int unsigned MAX_HOLES_DEF = 16;
  localparam int unsigned CNT_OUT_W     = 5;
  localparam int unsigned IN_W          = 56;
  localparam int unsigned OUT_W         = 64;

  typedef enum logic [1:0] {
    ACT_ADD     = 2'd0,
    ACT_RESERVE = 2'd1,
    ACT_PROBE   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_FIT = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef struct packed {
    logic load;
    logic rd;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/worst_fit_hole_allocator.sv =====
// Worst-fit hole allocator: keeps up to MAX_HOLES free holes and a free total.
// After a word is accepted, the hole table memory is read one entry per cycle
// to find merge partners, a free entry and the largest fitting hole. A flush
// state then settles the compare on the last entry, and a commit state writes
// the table back and loads the output register. The next word is taken in the
// cycle after the commit, so a new word is never taken while one is in work.
// A result that is still waiting in the output register holds back the table
// write of the next word until the result is taken.
// No clearing pass follows reset.
module worst_fit_hole_allocator
  import wfha_pkg::*;
#(
  parameter int unsigned MAX_HOLES = MAX_HOLES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // action[1:0], region_start[18:2], region_end[35:19], req_size[52:36]
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // status[1:0], alloc_start[18:2], alloc_end[35:19], avail_total[52:36],
  // hole_count[57:53]
  output logic [OUT_W-1:0] m_axis_tdata
);

  cmd_t cmd;
  sts_t sts;

  logic [1:0]           status;
  logic [AW-1:0]        alloc_start, alloc_end, avail_total;
  logic [CNT_OUT_W-1:0] hole_count;

  wfha_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  wfha_dp #(
    .MAX_HOLES (MAX_HOLES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .action_i       (s_axis_tdata[1:0]),
    .region_start_i (s_axis_tdata[18:2]),
    .region_end_i   (s_axis_tdata[35:19]),
    .req_size_i     (s_axis_tdata[52:36]),
    .m_tready_i     (m_axis_tready),
    .m_tvalid_o     (m_axis_tvalid),
    .status_o       (status),
    .alloc_start_o  (alloc_start),
    .alloc_end_o    (alloc_end),
    .avail_total_o  (avail_total),
    .hole_count_o   (hole_count)
  );

  assign m_axis_tdata = {6'b0, hole_count, avail_total, alloc_end, alloc_start, status};

endmodule

// ===== rtl/wfha_ctrl.sv =====
module wfha_ctrl
  import wfha_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_COMMIT
  } state_e;

  state_e state_q;

  always_comb begin
    s_axis_tready = (state_q == S_IDLE);
    cmd_o.load    = (state_q == S_IDLE) && s_axis_tvalid;
    cmd_o.rd      = (state_q == S_SCAN);
    cmd_o.commit  = (state_q == S_COMMIT) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (sts_i.idx_last) state_q <= S_FLUSH;
        end
        S_FLUSH: begin
          state_q <= S_COMMIT;
        end
        S_COMMIT: begin
          if (sts_i.out_free) state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/wfha_dp.sv =====
module wfha_dp
  import wfha_pkg::*;
#(
  parameter int unsigned MAX_HOLES = MAX_HOLES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic [1:0]           action_i,
  input  logic [AW-1:0]        region_start_i,
  input  logic [AW-1:0]        region_end_i,
  input  logic [AW-1:0]        req_size_i,
  input  logic                 m_tready_i,
  output logic                 m_tvalid_o,
  output logic [1:0]           status_o,
  output logic [AW-1:0]        alloc_start_o,
  output logic [AW-1:0]        alloc_end_o,
  output logic [AW-1:0]        avail_total_o,
  output logic [CNT_OUT_W-1:0] hole_count_o
);

  localparam int unsigned IDX_W = $clog2(MAX_HOLES);
  localparam int unsigned CNT_W = $clog2(MAX_HOLES + 1);

  logic [AW-1:0] start_mem [MAX_HOLES];
  logic [AW-1:0] end_mem   [MAX_HOLES];

  logic [1:0]     act_q;
  logic [AW-1:0]  rs_q, re_q, sz_q;
  logic [IDX_W-1:0] idx_q, rd_idx_q;
  logic           rd_vld_q, rd_valid_q;
  logic [AW-1:0]  rd_start_q, rd_end_q;

  logic           best_fnd_q, below_fnd_q, above_fnd_q, slot_fnd_q;
  logic [IDX_W-1:0] best_idx_q, below_idx_q, above_idx_q, slot_idx_q;
  logic [AW-1:0]  best_sz_q, best_start_q, best_end_q, below_start_q, above_end_q;

  logic [MAX_HOLES-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [AW-1:0]        ft_q, ft_d;

  logic           o_vld_q;
  logic [1:0]     o_status_q;
  logic [AW-1:0]  o_astart_q, o_aend_q, o_avail_q;
  logic [CNT_W-1:0] o_cnt_q;

  logic           ws_en, we_en;
  logic [IDX_W-1:0] ws_addr, we_addr;
  logic [AW-1:0]  ws_data, we_data;
  logic [1:0]     status_d;
  logic [AW-1:0]  astart_d, aend_d;

  logic [AW-1:0]  hs;
  logic [AW-1:0]  new_end, span;
  logic [AW:0]    ft_sum;
  logic           hit;

  assign sts_o.idx_last = (idx_q == IDX_W'(MAX_HOLES - 1));
  assign sts_o.out_free = !o_vld_q || m_tready_i;

  assign hs      = rd_end_q - rd_start_q;
  assign hit     = best_fnd_q && (sz_q != '0);
  assign new_end = best_end_q - sz_q;
  assign span    = re_q - rs_q;
  assign ft_sum  = {1'b0, ft_q} + {1'b0, span};

  always_comb begin
    ws_en    = 1'b0;
    we_en    = 1'b0;
    ws_addr  = below_idx_q;
    we_addr  = below_idx_q;
    ws_data  = rs_q;
    we_data  = re_q;
    valid_d  = valid_q;
    cnt_d    = cnt_q;
    ft_d     = ft_q;
    status_d = ST_OK;
    astart_d = '0;
    aend_d   = '0;
    case (act_q)
      ACT_ADD: begin
        if (re_q > rs_q) begin
          if (below_fnd_q && above_fnd_q && (below_idx_q != above_idx_q)) begin
            ws_en   = 1'b1;
            we_en   = 1'b1;
            ws_addr = (below_idx_q < above_idx_q) ? below_idx_q : above_idx_q;
            we_addr = ws_addr;
            ws_data = below_start_q;
            we_data = above_end_q;
            valid_d[(below_idx_q < above_idx_q) ? above_idx_q : below_idx_q] = 1'b0;
            cnt_d   = cnt_q - CNT_W'(1);
          end else if (below_fnd_q) begin
            we_en   = 1'b1;
            we_addr = below_idx_q;
          end else if (above_fnd_q) begin
            ws_en   = 1'b1;
            ws_addr = above_idx_q;
          end else if (slot_fnd_q) begin
            ws_en   = 1'b1;
            we_en   = 1'b1;
            ws_addr = slot_idx_q;
            we_addr = slot_idx_q;
            valid_d[slot_idx_q] = 1'b1;
            cnt_d   = cnt_q + CNT_W'(1);
          end else begin
            status_d = ST_FULL;
          end
          if (status_d == ST_OK) begin
            ft_d = (ft_sum > {1'b0, ADDR_LIMIT}) ? ADDR_LIMIT : ft_sum[AW-1:0];
          end
        end
      end
      ACT_RESERVE: begin
        if (!hit) begin
          status_d = ST_NO_FIT;
        end else begin
          we_en    = 1'b1;
          we_addr  = best_idx_q;
          we_data  = new_end;
          aend_d   = best_end_q;
          astart_d = new_end;
          if (new_end == best_start_q) begin
            valid_d[best_idx_q] = 1'b0;
            cnt_d = cnt_q - CNT_W'(1);
          end
          ft_d = (ft_q > sz_q) ? (ft_q - sz_q) : '0;
        end
      end
      ACT_PROBE: begin
        if (!hit) status_d = ST_NO_FIT;
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && ws_en) start_mem[ws_addr] <= ws_data;
    if (cmd_i.commit && we_en) end_mem[we_addr] <= we_data;
    rd_start_q <= start_mem[idx_q];
    rd_end_q   <= end_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= action_i;
      rs_q  <= (region_start_i > ADDR_LIMIT) ? ADDR_LIMIT : region_start_i;
      re_q  <= (region_end_i > ADDR_LIMIT) ? ADDR_LIMIT : region_end_i;
      sz_q  <= req_size_i;
    end
    rd_idx_q   <= idx_q;
    rd_valid_q <= valid_q[idx_q];
    if (rd_vld_q && !rd_valid_q && !slot_fnd_q) slot_idx_q <= rd_idx_q;
    if (rd_vld_q && rd_valid_q) begin
      if (!below_fnd_q && (rd_end_q == rs_q)) begin
        below_idx_q   <= rd_idx_q;
        below_start_q <= rd_start_q;
      end
      if (!above_fnd_q && (rd_start_q == re_q)) begin
        above_idx_q <= rd_idx_q;
        above_end_q <= rd_end_q;
      end
      if ((hs >= sz_q) && (!best_fnd_q || (hs > best_sz_q) ||
          ((hs == best_sz_q) && (rd_start_q > best_start_q)))) begin
        best_idx_q   <= rd_idx_q;
        best_sz_q    <= hs;
        best_start_q <= rd_start_q;
        best_end_q   <= rd_end_q;
      end
    end
    if (cmd_i.commit) begin
      o_status_q <= status_d;
      o_astart_q <= astart_d;
      o_aend_q   <= aend_d;
      o_avail_q  <= ft_d;
      o_cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      best_fnd_q  <= 1'b0;
      below_fnd_q <= 1'b0;
      above_fnd_q <= 1'b0;
      slot_fnd_q  <= 1'b0;
      valid_q     <= '0;
      cnt_q       <= '0;
      ft_q        <= '0;
      o_vld_q     <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd;
      if (cmd_i.load) begin
        idx_q       <= '0;
        best_fnd_q  <= 1'b0;
        below_fnd_q <= 1'b0;
        above_fnd_q <= 1'b0;
        slot_fnd_q  <= 1'b0;
      end else begin
        if (cmd_i.rd) idx_q <= idx_q + IDX_W'(1);
        if (rd_vld_q && !rd_valid_q) slot_fnd_q <= 1'b1;
        if (rd_vld_q && rd_valid_q) begin
          if (rd_end_q == rs_q) below_fnd_q <= 1'b1;
          if (rd_start_q == re_q) above_fnd_q <= 1'b1;
          if (hs >= sz_q) best_fnd_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        valid_q <= valid_d;
        cnt_q   <= cnt_d;
        ft_q    <= ft_d;
        o_vld_q <= 1'b1;
      end else if (m_tready_i) begin
        o_vld_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o    = o_vld_q;
  assign status_o      = o_status_q;
  assign alloc_start_o = o_astart_q;
  assign alloc_end_o   = o_aend_q;
  assign avail_total_o = o_avail_q;
  assign hole_count_o  = CNT_OUT_W'(o_cnt_q);

  a_cnt_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == CNT_W'($countones(valid_q)))
    else $error("hole count out of step with valid bits");

  a_commit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!o_vld_q || m_tready_i))
    else $error("result overwritten before it was taken");

  a_free_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ft_q <= ADDR_LIMIT)
    else $error("free total beyond address space");

  a_reserve_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && (act_q == ACT_RESERVE) && (status_d == ST_OK))
      |=> ((o_aend_q - o_astart_q) == $past(sz_q)))
    else $error("reserved block size differs from request");

  a_full_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && (status_d == ST_FULL)) |=> (cnt_q == $past(cnt_q)))
    else $error("table-full add changed the hole count");

endmodule

// ===== test/wfha_checker.sv =====
`timescale 1ns / 1ps

module wfha_checker
  import wfha_pkg::*;
#(
  parameter int unsigned HOLES = MAX_HOLES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  // action[1:0], region_start[18:2], region_end[35:19], req_size[52:36]
  input  logic [IN_W-1:0]  s_axis_tdata,
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // status[1:0], alloc_start[18:2], alloc_end[35:19], avail_total[52:36],
  // hole_count[57:53]
  input  logic [OUT_W-1:0] m_axis_tdata,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o,
  output int unsigned      checked_o,
  output int unsigned      full_seen_o
);

  typedef struct packed {
    status_e              status;
    logic [AW-1:0]        blk_lo;
    logic [AW-1:0]        blk_hi;
    logic [AW-1:0]        avail;
    logic [CNT_OUT_W-1:0] holes;
  } alloc_reply_t;

  logic [AW-1:0] hole_lo [HOLES];
  logic [AW-1:0] hole_hi [HOLES];
  bit            hole_used [HOLES];
  logic [AW:0]   free_sum;

  alloc_reply_t  replies_due [$];

  initial begin
    foreach (hole_used[i]) hole_used[i] = 1'b0;
    free_sum     = '0;
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
    full_seen_o  = 0;
  end

  function automatic logic [AW-1:0] clamp_addr(input logic [AW-1:0] a);
    return (a > ADDR_LIMIT) ? ADDR_LIMIT : a;
  endfunction

  function automatic int find_widest(input logic [AW-1:0] sz);
    int            pick;
    logic [AW-1:0] span;
    logic [AW-1:0] pick_span;
    pick      = -1;
    pick_span = '0;
    if (sz == '0) return -1;
    for (int i = 0; i < HOLES; i++) begin
      if (hole_used[i]) begin
        span = hole_hi[i] - hole_lo[i];
        if (span >= sz) begin
          if (pick < 0 || span > pick_span ||
              (span == pick_span && hole_lo[i] > hole_lo[pick])) begin
            pick      = i;
            pick_span = span;
          end
        end
      end
    end
    return pick;
  endfunction

  function automatic status_e free_region(input logic [AW-1:0] s, input logic [AW-1:0] e);
    int            below;
    int            above;
    int            slot;
    int            keep;
    int            drop;
    logic [AW-1:0] ns;
    logic [AW-1:0] ne;
    below = -1;
    above = -1;
    slot  = -1;
    if (e <= s) return ST_OK;
    for (int i = 0; i < HOLES; i++) begin
      if (!hole_used[i]) begin
        if (slot < 0) slot = i;
      end else begin
        if (below < 0 && hole_hi[i] == s) below = i;
        if (above < 0 && hole_lo[i] == e) above = i;
      end
    end
    if (below >= 0 && above >= 0 && below != above) begin
      keep = (below < above) ? below : above;
      drop = (below < above) ? above : below;
      ns = hole_lo[below];
      ne = hole_hi[above];
      hole_lo[keep]   = ns;
      hole_hi[keep]   = ne;
      hole_used[drop] = 1'b0;
    end else if (below >= 0) begin
      hole_hi[below] = e;
    end else if (above >= 0) begin
      hole_lo[above] = s;
    end else if (slot < 0) begin
      return ST_FULL;
    end else begin
      hole_lo[slot]   = s;
      hole_hi[slot]   = e;
      hole_used[slot] = 1'b1;
    end
    free_sum = free_sum + ((AW + 1)'(e) - (AW + 1)'(s));
    if (free_sum > (AW + 1)'(ADDR_LIMIT)) free_sum = (AW + 1)'(ADDR_LIMIT);
    return ST_OK;
  endfunction

  function automatic alloc_reply_t predict_reply(input logic [IN_W-1:0] word);
    logic [1:0]    act;
    logic [AW-1:0] rs;
    logic [AW-1:0] re;
    logic [AW-1:0] sz;
    alloc_reply_t  r;
    int            h;
    int unsigned   n;
    act = word[1:0];
    rs  = clamp_addr(word[18:2]);
    re  = clamp_addr(word[35:19]);
    sz  = word[52:36];
    r   = '0;
    r.status = ST_OK;
    if (act == ACT_ADD) begin
      r.status = free_region(rs, re);
    end else if (act == ACT_RESERVE) begin
      h = find_widest(sz);
      if (h < 0) begin
        r.status = ST_NO_FIT;
      end else begin
        r.blk_hi   = hole_hi[h];
        hole_hi[h] = hole_hi[h] - sz;
        r.blk_lo   = hole_hi[h];
        if (hole_hi[h] == hole_lo[h]) hole_used[h] = 1'b0;
        free_sum = (free_sum > (AW + 1)'(sz)) ? free_sum - (AW + 1)'(sz) : '0;
      end
    end else if (act == ACT_PROBE) begin
      if (find_widest(sz) < 0) r.status = ST_NO_FIT;
    end
    n = 0;
    foreach (hole_used[i]) if (hole_used[i]) n++;
    r.avail = free_sum[AW-1:0];
    r.holes = n[CNT_OUT_W-1:0];
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i) begin
    alloc_reply_t want;
    logic [OUT_W-1:0] got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) replies_due.push_back(predict_reply(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (got[1:0] == ST_FULL) full_seen_o++;
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, got);
          fail_count_o++;
        end else begin
          want = replies_due.pop_front();
          checked_o++;
          check_field("status", want.status, got[1:0]);
          check_field("alloc_start", want.blk_lo, got[18:2]);
          check_field("alloc_end", want.blk_hi, got[35:19]);
          check_field("avail_total", want.avail, got[52:36]);
          check_field("hole_count", want.holes, got[57:53]);
        end
      end
      pending_o = replies_due.size();
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import wfha_pkg::*;

  localparam logic [1:0]  ACT_SPARE   = 2'd3;
  localparam int unsigned BATCHES     = 15;
  localparam int unsigned BATCH_WORDS = 110;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 40;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned full_seen;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_busy_pct = 0;
  int unsigned rx_stall = 0;
  int unsigned quiet_cycles = 0;
  int unsigned act_seen [4] = '{0, 0, 0, 0};

  always #1 clk_i = ~clk_i;

  worst_fit_hole_allocator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  wfha_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .full_seen_o   (full_seen)
  );

  always @(negedge clk_i) begin
    if (rx_stall > 0) begin
      rx_stall--;
      m_axis_tready <= 1'b0;
    end else if (rx_busy_pct != 0 && $urandom_range(0, 99) < rx_busy_pct) begin
      rx_stall = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic idle_sender();
    int unsigned n;
    n = 0;
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
    end
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic send_word(input logic [1:0] act, input logic [AW-1:0] rs,
                           input logic [AW-1:0] re, input logic [AW-1:0] sz);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({sz, re, rs, act});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    act_seen[act]++;
    @(negedge clk_i);
    idle_sender();
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
  endtask

  function automatic logic [AW-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r == 0) return '0;
    if (r < 4) return AW'($urandom_range(1, 65536));
    if (r < 15) return AW'($urandom_range(1, 400));
    return AW'($urandom_range(1, 24));
  endfunction

  task automatic random_word(input int unsigned base, input int unsigned span,
                             input int unsigned add_pct, input bit fill);
    int unsigned   pick;
    int unsigned   len;
    logic [AW-1:0] lo;
    pick = $urandom_range(0, 99);
    len  = fill ? $urandom_range(1, 4) : 8 * $urandom_range(1, 6);
    if ($urandom_range(0, 7) == 0) len = $urandom_range(1, 40);
    lo = AW'(base + 8 * $urandom_range(0, span - 1));
    if (pick < 4) begin
      send_word(2'($urandom()), AW'($urandom()), AW'($urandom()), AW'($urandom()));
    end else if (pick == 4) begin
      // big region to push the free total to its ceiling
      send_word(ACT_ADD, AW'($urandom_range(0, 2000)), AW'($urandom_range(50000, 70000)),
                AW'($urandom()));
    end else if (pick == 5) begin
      send_word(ACT_ADD, lo, lo - AW'($urandom_range(0, 8)), AW'($urandom()));
    end else if (pick < 4 + add_pct) begin
      send_word(ACT_ADD, lo, lo + AW'(len), AW'($urandom()));
    end else if ($urandom_range(0, 2) != 0) begin
      send_word(ACT_RESERVE, AW'($urandom()), AW'($urandom()), pick_size());
    end else begin
      send_word(ACT_PROBE, AW'($urandom()), AW'($urandom()), pick_size());
    end
  endtask

  initial begin
    int unsigned span;
    int unsigned base;
    int unsigned add_pct;
    bit          fill;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_word(ACT_PROBE, '0, '0, AW'(1));
    send_word(ACT_RESERVE, '0, '0, '1);
    send_word(ACT_ADD, AW'(100), AW'(100), '0);
    send_word(ACT_ADD, AW'(200), AW'(150), '0);
    send_word(ACT_SPARE, '1, '1, '1);
    send_word(ACT_ADD, '1, '1, '0);
    send_word(ACT_ADD, AW'(60000), '1, '0);
    send_word(ACT_ADD, AW'(1000), AW'(2000), '0);
    send_word(ACT_ADD, AW'(3000), AW'(4000), '0);
    send_word(ACT_ADD, AW'(2000), AW'(3000), '0);
    send_word(ACT_ADD, AW'(500), AW'(1000), '0);
    send_word(ACT_ADD, AW'(4000), AW'(4500), '0);
    send_word(ACT_ADD, '0, AW'(65536), '0);
    send_word(ACT_RESERVE, '0, '0, '0);
    send_word(ACT_PROBE, '0, '0, '0);
    send_word(ACT_PROBE, '0, '0, AW'(65536));
    send_word(ACT_RESERVE, '0, '0, AW'(65536));
    send_word(ACT_RESERVE, '0, '0, AW'(1436));
    send_word(ACT_RESERVE, '0, '0, AW'(100));
    send_word(ACT_RESERVE, '0, '0, AW'(4000));
    send_word(ACT_RESERVE, '0, '0, AW'(4000));
    send_word(ACT_ADD, AW'(5000), AW'(5100), '0);
    send_word(ACT_ADD, AW'(5000), AW'(5100), '0);
    send_word(ACT_RESERVE, '0, '0, AW'(50));
    send_word(ACT_ADD, AW'(4950), AW'(5000), '0);
    drain();

    for (int b = 0; b < BATCHES; b++) begin
      span    = (b % 3 == 0) ? 16 : ((b % 3 == 1) ? 64 : 128);
      fill    = (b % 3 == 1);
      add_pct = fill ? 55 : ((b % 2 == 1) ? 45 : 30);
      base    = (b == BATCHES - 1) ? 65536 - 8 * span
                                   : 8 * $urandom_range(0, (60000 - 8 * span) / 8);
      tx_idle_pct = (b % 4 == 0) ? 0 : ((b % 4 == 1) ? 15 : 50);
      rx_busy_pct = (b % 4 == 3) ? 0 : ((b % 4 == 0) ? 20 : 50);
      for (int k = 0; k < BATCH_WORDS; k++) random_word(base, span, add_pct, fill);
      if (b % 2 == 0) drain();
    end

    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("words sent: %0d add, %0d reserve, %0d probe, %0d unused code",
             act_seen[ACT_ADD], act_seen[ACT_RESERVE], act_seen[ACT_PROBE],
             act_seen[ACT_SPARE]);
    $display("results compared: %0d, of them %0d with the hole table full",
             checked, full_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
